>>> hdl/krbs_pkg.sv
// Package for the k-mer reverse-complement bucket splitter.
// Holds field widths, configuration register indexes and limits.
// No dependencies.
package krbs_pkg;

  // Payload field widths.
  localparam int unsigned KmerW   = 64;
  localparam int unsigned CountW  = 16;
  localparam int unsigned BucketW = 16;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KMER_LEN    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUCKET_BITS = 2'd1;

  // Register widths, reset values and limits.
  localparam int unsigned LenW = 6;
  localparam int unsigned BbW  = 5;
  localparam logic [LenW-1:0] MAX_BASES      = 6'd32;
  localparam logic [LenW-1:0] KMER_LEN_RST   = 6'd32;
  localparam logic [BbW-1:0]  MAX_BKT_BITS   = 5'd16;
  localparam logic [BbW-1:0]  BKT_BITS_RST   = 5'd1;

endpackage

>>> hdl/kmer_revcomp_bucket_split_unit.sv
// Top level of the k-mer reverse-complement bucket splitter.
// Three-stage pipeline with a two-phase output stage; uses krbs_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  kmer_in_i, count_in_i
//   out      output     out_valid_o/out_stall_i kmer_out_o, count_out_o, bucket_o,
//                                              is_complement_o, last_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An accepted entry passes through the stage 1, stage 2 and stage 3 registers
// before its first result shows on the output.
// The output stage gives one result for a palindrome and two otherwise, the
// entry and then its complement, so with no stall on the output it sets the pace.
// Reset clears all valid bits and loads kmer_len = 32 and bucket_bits = 1.
// A stall on the output backs up stage by stage; no entry is lost or repeated.
module kmer_revcomp_bucket_split_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [krbs_pkg::KmerW-1:0]     kmer_in_i,
  input  logic [krbs_pkg::CountW-1:0]    count_in_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [krbs_pkg::KmerW-1:0]     kmer_out_o,
  output logic [krbs_pkg::CountW-1:0]    count_out_o,
  output logic [krbs_pkg::BucketW-1:0]   bucket_o,
  output logic                           is_complement_o,
  output logic                           last_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [krbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [krbs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import krbs_pkg::*;

  // Reverses the order of the 2-bit bases in a word.
  function automatic logic [KmerW-1:0] rev_pairs(input logic [KmerW-1:0] x);
    logic [KmerW-1:0] r;
    r = '0;
    for (int i = 0; i < KmerW / 2; i++) begin
      r[2*i +: 2] = x[KmerW-2-2*i +: 2];
    end
    return r;
  endfunction

  // Top bb bits of a word as a bucket number; bb is already saturated.
  function automatic logic [BucketW-1:0] bucket_of(input logic [KmerW-1:0] v,
                                                   input logic [BbW-1:0]   bb);
    logic [BucketW-1:0] top;
    top = v[KmerW-1 -: BucketW];
    if (bb == '0) begin
      return '0;
    end
    return top >> (MAX_BKT_BITS - bb);
  endfunction

  // Configuration registers.
  logic [LenW-1:0] kmer_len_q;
  logic [BbW-1:0]  bucket_bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q    <= KMER_LEN_RST;
      bucket_bits_q <= BKT_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KMER_LEN:    kmer_len_q    <= cfg_data_i[LenW-1:0];
        CFG_BUCKET_BITS: bucket_bits_q <= cfg_data_i[BbW-1:0];
        default:         ;
      endcase
    end
  end

  // Saturated register values.
  logic [LenW-1:0] len_eff;
  logic [BbW-1:0]  bb_eff;

  assign len_eff = (kmer_len_q > MAX_BASES) ? MAX_BASES : kmer_len_q;
  assign bb_eff  = (bucket_bits_q > MAX_BKT_BITS) ? MAX_BKT_BITS : bucket_bits_q;

  // Pipeline valid bits and the flow control between stages.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s3_phase_q;
  logic s3_leave, s3_ready, s2_ready, s1_ready;
  logic s3_pal_q;

  assign s3_leave   = s3_valid_q && !out_stall_i && (s3_pal_q || s3_phase_q);
  assign s3_ready   = !s3_valid_q || s3_leave;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // Stage 1: mask off the pad bits and work out the alignment shift.
  logic [KmerW-1:0]  s1_mask_d, s1_mask_q;
  logic [KmerW-1:0]  s1_fwd_q;
  logic [CountW-1:0] s1_cnt_q;
  logic [LenW:0]     s1_sh_full;
  logic [LenW-1:0]   s1_sh_q;

  assign s1_sh_full = 7'd64 - {len_eff, 1'b0};
  assign s1_mask_d  = (len_eff == '0) ? '0 : ({KmerW{1'b1}} << s1_sh_full[LenW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_mask_q <= s1_mask_d;
      s1_fwd_q  <= kmer_in_i & s1_mask_d;
      s1_cnt_q  <= count_in_i;
      s1_sh_q   <= s1_sh_full[LenW-1:0];
    end
  end

  // Stage 2: reverse complement, realigned to the top of the word.
  logic [KmerW-1:0]  s2_fwd_q, s2_rc_q;
  logic [CountW-1:0] s2_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_fwd_q <= s1_fwd_q;
      s2_rc_q  <= (rev_pairs(~s1_fwd_q) << s1_sh_q) & s1_mask_q;
      s2_cnt_q <= s1_cnt_q;
    end
  end

  // Stage 3: palindrome test and bucket numbers; this stage drives the output.
  logic [KmerW-1:0]   s3_fwd_q, s3_rc_q;
  logic [CountW-1:0]  s3_cnt_q;
  logic [BucketW-1:0] s3_bkt_fwd_q, s3_bkt_rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s3_phase_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
      s3_phase_q <= 1'b0;
    end else if (s3_valid_q && !out_stall_i) begin
      // First result of a non-palindrome taken; the complement follows.
      s3_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_fwd_q     <= s2_fwd_q;
      s3_rc_q      <= s2_rc_q;
      s3_cnt_q     <= s2_cnt_q;
      s3_pal_q     <= (s2_fwd_q == s2_rc_q);
      s3_bkt_fwd_q <= bucket_of(s2_fwd_q, bb_eff);
      s3_bkt_rc_q  <= bucket_of(s2_rc_q, bb_eff);
    end
  end

  // Output selection by phase.
  assign out_valid_o     = s3_valid_q;
  assign kmer_out_o      = s3_phase_q ? s3_rc_q : s3_fwd_q;
  assign count_out_o     = s3_cnt_q;
  assign bucket_o        = s3_phase_q ? s3_bkt_rc_q : s3_bkt_fwd_q;
  assign is_complement_o = s3_phase_q;
  assign last_o          = s3_phase_q || s3_pal_q;

endmodule

>>> hdl/krbs_checker.sv
// Port-level checker for the k-mer reverse-complement bucket splitter.
// Uses krbs_pkg; bound to kmer_revcomp_bucket_split_unit at the end.
module krbs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [krbs_pkg::CountW-1:0]    count_out_o,
  input logic                           is_complement_o,
  input logic                           last_o
);
  import krbs_pkg::*;

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // The complement is always the final result of its entry.
  a_comp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_complement_o |-> last_o)
    else $error("complement result not marked last");

  // A taken non-final result is followed at once by its complement, same count.
  a_comp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && is_complement_o && (count_out_o == $past(count_out_o)))
    else $error("complement transaction missing after forward result");

  // An edge seen in reset leaves no result on the output after it.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind kmer_revcomp_bucket_split_unit krbs_checker u_krbs_checker (.*);

>>> tb/kmer_revcomp_bucket_split_unit_tb.sv
// Self-checking testbench for kmer_revcomp_bucket_split_unit.
// Drives k-mer entries and register writes, predicts every result in place.
// Depends on krbs_pkg and the top level of the block only.
`timescale 1ns / 100ps

module kmer_revcomp_bucket_split_unit_tb;
  import krbs_pkg::*;

  localparam int unsigned LIMIT        = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_WAIT     = 17;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned RAND_ITEMS   = 100;

  // Indexes that select no register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [KmerW-1:0]  kmer;
    logic [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [KmerW-1:0]   kmer;
    logic [CountW-1:0]  count;
    logic [BucketW-1:0] bucket;
    logic               is_comp;
    logic               last;
  } split_res_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [KmerW-1:0]    kmer_in_i       = '0;
  logic [CountW-1:0]   count_in_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [KmerW-1:0]    kmer_out_o;
  logic [CountW-1:0]   count_out_o;
  logic [BucketW-1:0]  bucket_o;
  logic                is_complement_o;
  logic                last_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  // Register copies used for prediction.
  logic [LenW-1:0] len_reg = KMER_LEN_RST;
  logic [BbW-1:0]  bb_reg  = BKT_BITS_RST;

  entry_t      entry_q[$];
  split_res_t  split_exp_q[$];
  entry_t      next_entry;
  int unsigned src_wait  = 0;
  int unsigned snk_wait  = 0;
  int unsigned snk_draw;
  logic        src_burst = 1'b0;
  logic        snk_burst = 1'b0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  kmer_revcomp_bucket_split_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kmer_in_i      (kmer_in_i),
    .count_in_i     (count_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kmer_out_o     (kmer_out_o),
    .count_out_o    (count_out_o),
    .bucket_o       (bucket_o),
    .is_complement_o(is_complement_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Number of bases actually used, after saturation.
  function automatic int unsigned eff_len();
    return 32'((len_reg > MAX_BASES) ? MAX_BASES : len_reg);
  endfunction

  // Top bucket_bits bits of a left-justified k-mer.
  function automatic logic [BucketW-1:0] bucket_of_kmer(logic [KmerW-1:0] v);
    int unsigned        b;
    logic [BucketW-1:0] bkt;
    b = 32'((bb_reg > MAX_BKT_BITS) ? MAX_BKT_BITS : bb_reg);
    if (b == 0) return '0;
    bkt = BucketW'(v >> (64 - b));
    return bkt;
  endfunction

  // Complement every base and reverse the order of all 32 base slots.
  function automatic logic [KmerW-1:0] flip_bases(logic [KmerW-1:0] v);
    logic [KmerW-1:0] inv;
    logic [KmerW-1:0] rev;
    inv = ~v;
    for (int i = 0; i < 32; i++) rev[2*i +: 2] = inv[62 - 2*i +: 2];
    return rev;
  endfunction

  // Expected results of one entry: the entry with its pad bits cleared, then its complement
  // unless the k-mer equals its own reverse complement.
  function automatic void predict_split(logic [KmerW-1:0] kmer, logic [CountW-1:0] count);
    int unsigned      k;
    int unsigned      sh;
    logic [KmerW-1:0] mask;
    logic [KmerW-1:0] fwd;
    logic [KmerW-1:0] rc;
    split_res_t       r;
    k = eff_len();
    if (k == 0) begin
      fwd = '0;
      rc  = '0;
    end else begin
      sh   = 64 - 2 * k;
      mask = ~64'd0 << sh;
      fwd  = kmer & mask;
      rc   = (flip_bases(fwd) << sh) & mask;
    end
    r.kmer    = fwd;
    r.count   = count;
    r.bucket  = bucket_of_kmer(fwd);
    r.is_comp = 1'b0;
    r.last    = (rc == fwd);
    split_exp_q.push_back(r);
    if (rc != fwd) begin
      r.kmer    = rc;
      r.bucket  = bucket_of_kmer(rc);
      r.is_comp = 1'b1;
      r.last    = 1'b1;
      split_exp_q.push_back(r);
    end
  endfunction

  function automatic int unsigned draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Random k-mer; for even lengths about a third are made palindromic.
  // Pad bits stay random.
  function automatic logic [KmerW-1:0] random_kmer(int unsigned k);
    logic [KmerW-1:0] v;
    v = {$urandom, $urandom};
    if (k >= 2 && k % 2 == 0 && $urandom_range(0, 2) == 0) begin
      for (int i = k / 2; i < k; i++) v[63 - 2*i -: 2] = ~v[63 - 2*(k - 1 - i) -: 2];
    end
    return v;
  endfunction

  task automatic queue_entry(logic [KmerW-1:0] kmer, logic [CountW-1:0] count);
    entry_t e;
    e.kmer  = kmer;
    e.count = count;
    entry_q.push_back(e);
  endtask

  task automatic report_mismatch(string field, logic [KmerW-1:0] want, logic [KmerW-1:0] got);
    err_cnt++;
    $display("%0t ERROR %s: expected %h, actual %h", $time, field, want, got);
  endtask

  // Compare one output transaction with the oldest expected result.
  task automatic check_result();
    split_res_t want;
    if (split_exp_q.size() == 0) begin
      err_cnt++;
      $display("%0t ERROR unexpected result: expected none, actual kmer_out %h",
               $time, kmer_out_o);
      return;
    end
    want = split_exp_q.pop_front();
    if (kmer_out_o !== want.kmer) report_mismatch("kmer_out", want.kmer, kmer_out_o);
    if (count_out_o !== want.count)
      report_mismatch("count_out", KmerW'(want.count), KmerW'(count_out_o));
    if (bucket_o !== want.bucket)
      report_mismatch("bucket", KmerW'(want.bucket), KmerW'(bucket_o));
    if (is_complement_o !== want.is_comp)
      report_mismatch("is_complement", KmerW'(want.is_comp), KmerW'(is_complement_o));
    if (last_o !== want.last) report_mismatch("last", KmerW'(want.last), KmerW'(last_o));
  endtask

  // One register write transaction; the copy follows once it is taken.
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_KMER_LEN) len_reg = data;
    else if (idx == CFG_BUCKET_BITS) bb_reg = data[BbW-1:0];
  endtask

  task automatic set_cfg(logic [CfgDataW-1:0] len, logic [CfgDataW-1:0] bb);
    cfg_write(CFG_KMER_LEN, len);
    cfg_write(CFG_BUCKET_BITS, bb);
  endtask

  // Wait until all entries are sent and all results are in, then let the
  // pipeline settle.
  task automatic wait_drain();
    do @(negedge clk_i); while (entry_q.size() != 0 || in_valid_i || split_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random settings, weighted toward legal values with the extremes mixed in.
  task automatic random_cfg();
    logic [CfgDataW-1:0] len;
    logic [CfgDataW-1:0] bb;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = 6'd32;
      2:       len = CfgDataW'($urandom_range(33, 63));
      default: len = CfgDataW'($urandom_range(1, 32));
    endcase
    case ($urandom_range(0, 9))
      0:       bb = '0;
      1:       bb = 6'd16;
      2:       bb = CfgDataW'($urandom_range(17, 63));
      default: bb = CfgDataW'($urandom_range(1, 16));
    endcase
    set_cfg(len, bb);
  endtask

  task automatic run_random(int unsigned n);
    @(negedge clk_i);
    for (int i = 0; i < n; i++)
      queue_entry(random_kmer(eff_len()), CountW'($urandom_range(0, 65535)));
  endtask

  // Input driver: one transaction per pending entry, with a random gap after each unless in burst mode.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_split(kmer_in_i, count_in_i);
      if (in_valid_i && in_stall_o) begin
        // Stalled: hold the payload.
      end else if (src_wait != 0) begin
        src_wait   <= src_wait - 1;
        in_valid_i <= 1'b0;
      end else if (entry_q.size() != 0) begin
        next_entry = entry_q.pop_front();
        in_valid_i <= 1'b1;
        kmer_in_i  <= next_entry.kmer;
        count_in_i <= next_entry.count;
        src_wait   <= draw_wait(src_burst);
        if ($urandom_range(0, 39) == 0) src_burst <= ~src_burst;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: checks each result, then draws a random stall, none in burst mode.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
        snk_draw = draw_wait(snk_burst);
        snk_wait    <= snk_draw;
        out_stall_i <= (snk_draw != 0);
        if ($urandom_range(0, 39) == 0) snk_burst <= ~snk_burst;
      end else if (snk_wait != 0) begin
        snk_wait    <= snk_wait - 1;
        out_stall_i <= (snk_wait > 1);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("%0t ERROR timeout after %0d cycles", $time, cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 32 bases, one bucket bit. All-A, all-T, palindromes.
    @(negedge clk_i);
    queue_entry(64'h0000_0000_0000_0000, 16'h0000);
    queue_entry(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    queue_entry(64'h3333_3333_3333_3333, 16'h0001);
    queue_entry(64'hCCCC_CCCC_CCCC_CCCC, 16'h8000);
    queue_entry(64'h1B1B_1B1B_1B1B_1B1B, 16'h5A5A);
    queue_entry({$urandom, $urandom}, CountW'($urandom_range(0, 65535)));
    wait_drain();

    // Writes to unused indexes must leave both registers alone.
    cfg_write(CFG_SPARE_LO, 6'h3F);
    cfg_write(CFG_SPARE_HI, 6'h00);
    @(negedge clk_i);
    queue_entry(64'h0123_4567_89AB_CDEF, 16'h1234);
    wait_drain();

    // Short k-mers with pad bits set on input, widest bucket.
    set_cfg(6'd4, 6'd16);
    @(negedge clk_i);
    queue_entry(64'h1B00_0000_0000_0000, 16'h0002);
    queue_entry(64'h1BFF_FFFF_FFFF_FFFF, 16'h0003);
    queue_entry(64'h00FF_FFFF_FFFF_FFFF, 16'h0004);
    wait_drain();

    // Empty k-mer and zero bucket bits.
    set_cfg(6'd0, 6'd0);
    @(negedge clk_i);
    queue_entry({$urandom, $urandom}, 16'h00FF);
    queue_entry(64'hFFFF_FFFF_FFFF_FFFF, 16'hFF00);
    wait_drain();

    // Both registers above their limits, so both saturate.
    set_cfg(6'h3F, 6'h3F);
    @(negedge clk_i);
    queue_entry(64'h0123_4567_89AB_CDEF, 16'hAAAA);
    queue_entry(64'h3333_3333_3333_3333, 16'h5555);
    wait_drain();

    // Single base.
    set_cfg(6'd1, 6'd2);
    @(negedge clk_i);
    queue_entry(64'h4000_0000_0000_0000, 16'h0010);
    queue_entry(64'hFFFF_FFFF_FFFF_FFFF, 16'h0020);
    wait_drain();

    // Odd length, bucket bits just above the limit.
    set_cfg(6'd31, 6'd17);
    @(negedge clk_i);
    queue_entry({$urandom, $urandom}, CountW'($urandom_range(0, 65535)));
    wait_drain();

    // Bucket widths that are whole bytes.
    set_cfg(6'd32, 6'd8);
    @(negedge clk_i);
    queue_entry({$urandom, $urandom}, CountW'($urandom_range(0, 65535)));
    wait_drain();
    set_cfg(6'd16, 6'd16);
    @(negedge clk_i);
    queue_entry(64'h1B1B_1B1B_0000_0000 | 64'(32'($urandom)),
                CountW'($urandom_range(0, 65535)));
    wait_drain();

    // Random phases, the first two at the extreme settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) set_cfg(6'd1, 6'd1);
      else if (p == 1) set_cfg(6'd32, 6'd16);
      else random_cfg();
      run_random(RAND_ITEMS);
      wait_drain();
    end

    if (err_cnt == 0 && split_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/krbs_pkg.sv
hdl/kmer_revcomp_bucket_split_unit.sv
hdl/krbs_checker.sv
tb/kmer_revcomp_bucket_split_unit_tb.sv
